@@ rtl/core/ffcp_pkg.sv @@
// ffcp_pkg: beat types and fixed field constants for the first-fit component packer
// depends on nothing; used by first_fit_component_packer_unit and ffcp_slot_ram users
`default_nettype none

package ffcp_pkg;

    localparam int CLASS_W = 2;

    // precision class codes
    localparam logic [CLASS_W-1:0] CLASS_FIXED = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_HALF  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_FLOAT = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_ALIAS = 2'd3;

    typedef struct packed {
        logic [2:0]         comp_count;
        logic [CLASS_W-1:0] precision_class;
        logic               last_in_set;
    } t_in_beat;

    typedef struct packed {
        logic [3:0] slot_index;
        logic [1:0] comp_offset;
        logic       overflow;
    } t_out_beat;

endpackage

`default_nettype wire

@@ rtl/core/ffcp_slot_ram.sv @@
// ffcp_slot_ram: one-write one-read slot table memory, registered read data
// depends on nothing; instantiated by first_fit_component_packer_unit
`default_nettype none

module ffcp_slot_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/first_fit_component_packer_unit.sv @@
// first_fit_component_packer_unit: top level of the first-fit component packer
// depends on ffcp_pkg (beat types, class codes) and ffcp_slot_ram (slot table)
//
// usage
//   input channel: i_in_valid / o_in_stall / i_in_beat carry one item per beat
//   (component count, precision class, last-of-set mark)
//   output channel: o_out_valid / i_out_stall / o_out_beat carry one result per
//   item (slot index, component offset, overflow flag)
//   each item is scanned against the open slots from slot 0 upward; the slot
//   table (fill, class per slot) lives in a memory with registered read data
//   that is read one slot per cycle
//   the memory read port sets the scan rate: one slot is examined per cycle
//   one item is in flight at a time; o_in_stall stays high until its result has
//   moved into the output register
//   after a last-of-set item the open-slot count returns to zero, which closes
//   every slot; stale memory contents are never read since only slots below the
//   open count are scanned and opening a slot writes its whole entry
//   reset: open count zero, no result pending, ready for an item; no clearing
//   pass is needed
//   a stalled output holds its beat; a finished result waits for the output
//   register to drain and the input stays stalled meanwhile
`default_nettype none

module first_fit_component_packer_unit #(
    parameter int MAX_SLOTS  = 16,
    parameter int SLOT_WIDTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire ffcp_pkg::t_in_beat i_in_beat,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output ffcp_pkg::t_out_beat     o_out_beat
);

    // slot index, open count and fill widths
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int FW = $clog2(SLOT_WIDTH + 1);
    localparam int DW = ffcp_pkg::CLASS_W + FW;

    localparam logic [CW-1:0] OPEN_MAX = CW'(MAX_SLOTS);
    localparam logic [FW-1:0] FILL_MAX = FW'(SLOT_WIDTH);
    localparam logic [FW:0]   SUM_MAX  = (FW + 1)'(SLOT_WIDTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    t_state                       r_state;
    logic [CW-1:0]                r_open;     // slots 0..r_open-1 are open
    logic [CW-1:0]                r_scan;     // next slot to read
    logic                         r_chk_valid; // read data belongs to r_chk_idx
    logic [IW-1:0]                r_chk_idx;
    logic [FW-1:0]                r_need;
    logic [ffcp_pkg::CLASS_W-1:0] r_cls;
    logic                         r_last;
    ffcp_pkg::t_out_beat          r_res;
    logic                         r_out_valid;
    ffcp_pkg::t_out_beat          r_out;

    logic                         w_accept;
    logic                         w_issue;
    logic                         w_fits;
    logic                         w_miss;
    logic                         w_can_open;
    logic                         w_we;
    logic [IW-1:0]                w_waddr;
    logic [DW-1:0]                w_wdata;
    logic [DW-1:0]                w_rdata;
    logic [FW-1:0]                w_rd_fill;
    logic [ffcp_pkg::CLASS_W-1:0] w_rd_cls;
    logic [FW:0]                  w_sum;
    logic [FW-1:0]                n_need;
    logic [ffcp_pkg::CLASS_W-1:0] n_cls;
    logic [IW+3:0]                w_idx_ext;
    logic [FW+1:0]                w_off_ext;
    logic [IW-1:0]                w_res_idx;
    logic [FW-1:0]                w_res_off;

    assign w_accept = i_in_valid && !o_in_stall;

    // normalize the incoming item: zero count means one, saturate at slot width,
    // class code three is float
    always_comb begin
        if (i_in_beat.comp_count == 3'd0) begin
            n_need = FW'(1);
        end else if (int'(i_in_beat.comp_count) > SLOT_WIDTH) begin
            n_need = FILL_MAX;
        end else begin
            n_need = FW'(i_in_beat.comp_count);
        end
        if (i_in_beat.precision_class == ffcp_pkg::CLASS_ALIAS) begin
            n_cls = ffcp_pkg::CLASS_FLOAT;
        end else begin
            n_cls = i_in_beat.precision_class;
        end
    end

    // scan: issue one read per cycle, check the previous read's data
    assign w_issue    = (r_state == S_SCAN) && (r_scan < r_open);
    assign w_rd_fill  = w_rdata[FW-1:0];
    assign w_rd_cls   = w_rdata[DW-1 -: ffcp_pkg::CLASS_W];
    assign w_sum      = {1'b0, w_rd_fill} + {1'b0, r_need};
    assign w_fits     = (r_state == S_SCAN) && r_chk_valid && (w_sum <= SUM_MAX)
                        && (w_rd_cls == r_cls);
    // nothing in flight and every open slot checked
    assign w_miss     = (r_state == S_SCAN) && !r_chk_valid && (r_scan == r_open);
    assign w_can_open = (r_open < OPEN_MAX);

    // write back the grown fill, or the whole entry of a newly opened slot
    always_comb begin
        w_we    = w_fits || (w_miss && w_can_open);
        w_waddr = w_fits ? r_chk_idx : r_open[IW-1:0];
        w_wdata = w_fits ? {r_cls, w_sum[FW-1:0]} : {r_cls, r_need};
    end

    ffcp_slot_ram #(
        .DEPTH (MAX_SLOTS),
        .AW    (IW),
        .DW    (DW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_scan[IW-1:0]),
        .o_rdata (w_rdata)
    );

    // result fields, masked to the output widths
    assign w_res_idx = w_fits ? r_chk_idx : r_open[IW-1:0];
    assign w_res_off = w_fits ? w_rd_fill : '0;
    assign w_idx_ext = {4'b0, w_res_idx};
    assign w_off_ext = {2'b0, w_res_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: loads a finished result, empties once taken
            if ((r_state == S_OUT) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_chk_valid <= 1'b0;
                    if (w_accept) begin
                        r_need  <= n_need;
                        r_cls   <= n_cls;
                        r_last  <= i_in_beat.last_in_set;
                        r_scan  <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_chk_valid <= w_issue && !(w_fits || w_miss);
                    r_chk_idx   <= r_scan[IW-1:0];
                    if (w_issue) begin
                        r_scan <= r_scan + CW'(1);
                    end
                    if (w_fits || w_miss) begin
                        r_state     <= S_OUT;
                        if (w_fits || w_can_open) begin
                            r_res.slot_index  <= w_idx_ext[3:0];
                            r_res.comp_offset <= w_off_ext[1:0];
                            r_res.overflow    <= 1'b0;
                        end else begin
                            // table full: item not placed
                            r_res.slot_index  <= '0;
                            r_res.comp_offset <= '0;
                            r_res.overflow    <= 1'b1;
                        end
                        // last item of a set closes every slot
                        if (r_last) begin
                            r_open <= '0;
                        end else if (w_miss && w_can_open) begin
                            r_open <= r_open + CW'(1);
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out       <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // open count never passes the table depth
    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open <= OPEN_MAX)
        else $error("open slot count above table depth");

    // a checked slot is always an open one
    a_chk_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid |-> ({1'b0, r_chk_idx} < {1'b0, r_open}))
        else $error("checked slot is not open");

    // an accepted beat starts a scan from slot zero
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN) && (r_scan == '0) && !r_chk_valid)
        else $error("scan did not start at slot zero");

    // overflow beats carry zero index and offset
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.overflow) |->
            (o_out_beat.slot_index == 4'd0) && (o_out_beat.comp_offset == 2'd0))
        else $error("overflow beat with nonzero placement");

    // a full table without a fit, on an item that is not last of a set, reports overflow and leaves the count alone
    a_full_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_miss && !w_can_open && !r_last) |=> r_res.overflow && (r_open == OPEN_MAX))
        else $error("full table did not overflow");

endmodule

`default_nettype wire
